// ----- design/prps_pkg.sv -----
// ----------------------------------------------------------------------------
// prps_pkg: shared types and constants for the positive run peak scorer
// default geometry, fixed result field widths and the stage control struct
// ----------------------------------------------------------------------------
package prps_pkg;

    localparam int PRPS_LINE_MAX    = 1024;
    localparam int PRPS_SAMPLE_BITS = 24;
    localparam int PRPS_INDEX_W     = 10;
    localparam int PRPS_SCORE_W     = 33;

    // control that travels with a pending result from tracker to scorer
    typedef struct packed {
        logic valid;
        logic found;
        logic line_end;
    } prps_ctl_t;

endpackage

// ----- design/prps_in_if.sv -----
// ----------------------------------------------------------------------------
// prps_in_if: sample channel
// valid/ready channel carrying one curvature sample and its end-of-line flag
// ----------------------------------------------------------------------------
interface prps_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in_line;

    modport source (output valid, output sample, output last_in_line, input ready);
    modport sink   (input valid, input sample, input last_in_line, output ready);
endinterface

// ----- design/prps_out_if.sv -----
// ----------------------------------------------------------------------------
// prps_out_if: result channel
// valid/ready channel carrying one scored peak or an end-of-line marker
// ----------------------------------------------------------------------------
interface prps_out_if
    import prps_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [PRPS_INDEX_W-1:0] peak_index;
    logic [PRPS_SCORE_W-1:0] peak_score;
    logic                    peak_found;
    logic                    line_end;

    modport source (output valid, output peak_index, output peak_score,
                    output peak_found, output line_end, input ready);
    modport sink   (input valid, input peak_index, input peak_score,
                    input peak_found, input line_end, output ready);
endinterface

// ----- design/positive_run_peak_scorer_unit.sv -----
// ----------------------------------------------------------------------------
// positive_run_peak_scorer_unit: curvature run peak scorer
// scores each run of positive curvature samples along an image line
// ----------------------------------------------------------------------------
// usage
//   samples: one beat per curvature sample, signed with 16 fraction bits,
//     last_in_line marks the final sample of a line
//   results: one beat when a positive run closes, plus exactly one beat
//     with line_end set per line, shared by a run closing there; peak_found
//     clear means no peak, and then peak_index and peak_score read zero
//   path: the beat closing a run goes from the input register through the
//     tracking stage into the pending result, then multiply and result register
//   throughput: one sample per cycle while results.ready holds; the run
//     compare and the single score multiply each sit in their own register stage
//   stall: a held results.ready fills the result register, then the pending
//     result stage, then the input register; samples.ready drops only when
//     all three are full, and no beat is lost or repeated
//   reset: rst_n clears all valids and the run state; the line position
//     restarts at zero, so the first sample after reset opens a new line
//   long lines: the position saturates at LINE_MAX - 1
// ----------------------------------------------------------------------------
module positive_run_peak_scorer_unit
    import prps_pkg::*;
#(
    parameter int LINE_MAX    = PRPS_LINE_MAX,
    parameter int SAMPLE_BITS = PRPS_SAMPLE_BITS,
    localparam int POS_BITS   = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1,
    localparam int LEN_W      = POS_BITS + 1,
    localparam int BEST_W     = SAMPLE_BITS - 1
)(
    input  logic       clk,
    input  logic       rst_n,
    prps_in_if.sink    samples,
    prps_out_if.source results
);

    // pending result between tracking and scoring
    prps_ctl_t               em_ctl;
    logic [BEST_W-1:0]       em_best;
    logic [LEN_W-1:0]        em_len;
    logic [PRPS_INDEX_W-1:0] em_index;
    logic                    em_ready;

    // run tracking: positive-run detection, first-maximum capture, line position
    prps_tracker #(
        .LINE_MAX    (LINE_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .em_ctl   (em_ctl),
        .em_best  (em_best),
        .em_len   (em_len),
        .em_index (em_index),
        .em_ready (em_ready)
    );

    // scoring: peak value times run length into the result register
    prps_scorer #(
        .LINE_MAX    (LINE_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scorer (
        .clk      (clk),
        .rst_n    (rst_n),
        .em_ctl   (em_ctl),
        .em_best  (em_best),
        .em_len   (em_len),
        .em_index (em_index),
        .em_ready (em_ready),
        .results  (results)
    );

endmodule

// ----- design/prps_tracker.sv -----
// ----------------------------------------------------------------------------
// prps_tracker: run tracking stage
// input register, run/peak state and the register holding a pending result
// ----------------------------------------------------------------------------
module prps_tracker
    import prps_pkg::*;
#(
    parameter int LINE_MAX    = PRPS_LINE_MAX,
    parameter int SAMPLE_BITS = PRPS_SAMPLE_BITS,
    localparam int POS_BITS   = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1,
    localparam int LEN_W      = POS_BITS + 1,
    localparam int BEST_W     = SAMPLE_BITS - 1
)(
    input  logic                    clk,
    input  logic                    rst_n,
    prps_in_if.sink                 samples,
    output prps_ctl_t               em_ctl,
    output logic [BEST_W-1:0]       em_best,
    output logic [LEN_W-1:0]        em_len,
    output logic [PRPS_INDEX_W-1:0] em_index,
    input  logic                    em_ready
);

    localparam int IDX_EXT = (POS_BITS > PRPS_INDEX_W) ? POS_BITS : PRPS_INDEX_W;
    localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(LINE_MAX - 1);

    // input register
    logic                   in_valid_reg, in_valid_next;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   in_last_reg;

    // run state
    logic                in_run_reg, in_run_next;
    logic [POS_BITS-1:0] run_begin_reg, run_begin_next;
    logic [BEST_W-1:0]   best_value_reg, best_value_next;
    logic [POS_BITS-1:0] best_pos_reg, best_pos_next;
    logic [POS_BITS-1:0] line_pos_reg, line_pos_next;

    // pending result
    prps_ctl_t                em_ctl_reg, em_ctl_next;
    logic [BEST_W-1:0]        em_best_reg, em_best_next;
    logic [LEN_W-1:0]         em_len_reg, em_len_next;
    logic [PRPS_INDEX_W-1:0]  em_index_reg, em_index_next;

    logic                 take;
    logic                 proc;
    logic                 positive;
    logic [BEST_W-1:0]    sval;
    logic                 emit;
    logic [IDX_EXT-1:0]   idx_ext;
    logic [POS_BITS-1:0]  idx_pos;

    assign proc          = in_valid_reg && (!em_ctl_reg.valid || em_ready);
    assign samples.ready = !in_valid_reg || proc;
    assign take          = samples.valid && samples.ready;
    assign in_valid_next = take ? 1'b1 : (proc ? 1'b0 : in_valid_reg);

    assign positive = !in_sample_reg[SAMPLE_BITS-1] && (|in_sample_reg);
    assign sval     = in_sample_reg[BEST_W-1:0];
    assign idx_ext  = IDX_EXT'(idx_pos);

    always_comb
    begin
        in_run_next     = in_run_reg;
        run_begin_next  = run_begin_reg;
        best_value_next = best_value_reg;
        best_pos_next   = best_pos_reg;
        line_pos_next   = line_pos_reg;
        emit            = 1'b0;
        em_ctl_next     = em_ctl_reg;
        em_best_next    = '0;
        em_len_next     = '0;
        idx_pos         = '0;

        if (in_last_reg && line_pos_reg == '0)
        begin
            // one-sample line scores nothing
            emit                 = 1'b1;
            em_ctl_next.found    = 1'b0;
            em_ctl_next.line_end = 1'b1;
            in_run_next          = 1'b0;
            line_pos_next        = '0;
        end
        else
        begin
            if (positive && !in_run_reg)
            begin
                in_run_next     = 1'b1;
                run_begin_next  = line_pos_reg;
                best_value_next = sval;
                best_pos_next   = line_pos_reg;
            end
            else if (!positive && in_run_reg)
            begin
                // run closed by a non-positive sample
                emit                 = 1'b1;
                em_ctl_next.found    = 1'b1;
                em_ctl_next.line_end = in_last_reg;
                em_best_next         = best_value_reg;
                em_len_next          = LEN_W'(line_pos_reg) - LEN_W'(run_begin_reg);
                idx_pos              = best_pos_reg;
                in_run_next          = 1'b0;
            end
            else if (in_run_reg && sval > best_value_reg)
            begin
                best_value_next = sval;
                best_pos_next   = line_pos_reg;
            end

            if (in_last_reg)
            begin
                if (!emit)
                begin
                    emit                 = 1'b1;
                    em_ctl_next.line_end = 1'b1;
                    em_ctl_next.found    = in_run_next;
                    if (in_run_next)
                    begin
                        // run still open at line end
                        em_best_next = best_value_next;
                        em_len_next  = LEN_W'(line_pos_reg) + LEN_W'(1)
                                       - LEN_W'(run_begin_next);
                        idx_pos      = best_pos_next;
                    end
                end
                in_run_next   = 1'b0;
                line_pos_next = '0;
            end
            else if (line_pos_reg < POS_LAST)
            begin
                line_pos_next = line_pos_reg + POS_BITS'(1);
            end
        end

        em_index_next = idx_ext[PRPS_INDEX_W-1:0];

        if (proc)
        begin
            em_ctl_next.valid = emit;
        end
        else
        begin
            em_ctl_next.valid = em_ready ? 1'b0 : em_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_run_reg     <= 1'b0;
            run_begin_reg  <= '0;
            best_value_reg <= '0;
            best_pos_reg   <= '0;
            line_pos_reg   <= '0;
            em_ctl_reg     <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (proc)
            begin
                in_run_reg     <= in_run_next;
                run_begin_reg  <= run_begin_next;
                best_value_reg <= best_value_next;
                best_pos_reg   <= best_pos_next;
                line_pos_reg   <= line_pos_next;
            end
            em_ctl_reg.valid <= em_ctl_next.valid;
            if (proc && emit)
            begin
                em_ctl_reg.found    <= em_ctl_next.found;
                em_ctl_reg.line_end <= em_ctl_next.line_end;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_sample_reg <= samples.sample;
            in_last_reg   <= samples.last_in_line;
        end
        if (proc && emit)
        begin
            em_best_reg  <= em_best_next;
            em_len_reg   <= em_len_next;
            em_index_reg <= em_index_next;
        end
    end

    assign em_ctl   = em_ctl_reg;
    assign em_best  = em_best_reg;
    assign em_len   = em_len_reg;
    assign em_index = em_index_reg;

endmodule

// ----- design/prps_scorer.sv -----
// ----------------------------------------------------------------------------
// prps_scorer: score multiply and result register
// peak value times run length, registered onto the result channel
// ----------------------------------------------------------------------------
module prps_scorer
    import prps_pkg::*;
#(
    parameter int LINE_MAX    = PRPS_LINE_MAX,
    parameter int SAMPLE_BITS = PRPS_SAMPLE_BITS,
    localparam int POS_BITS   = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1,
    localparam int LEN_W      = POS_BITS + 1,
    localparam int BEST_W     = SAMPLE_BITS - 1
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  prps_ctl_t               em_ctl,
    input  logic [BEST_W-1:0]       em_best,
    input  logic [LEN_W-1:0]        em_len,
    input  logic [PRPS_INDEX_W-1:0] em_index,
    output logic                    em_ready,
    prps_out_if.source              results
);

    localparam int PROD_W = BEST_W + LEN_W;
    localparam int EXT_W  = (PROD_W > PRPS_SCORE_W) ? PROD_W : PRPS_SCORE_W;

    logic                    out_valid_reg, out_valid_next;
    logic [PRPS_INDEX_W-1:0] out_index_reg;
    logic [PRPS_SCORE_W-1:0] out_score_reg;
    logic                    out_found_reg;
    logic                    out_end_reg;
    logic                    load;
    logic [PROD_W-1:0]       prod;
    logic [EXT_W-1:0]        prod_ext;

    assign em_ready       = !out_valid_reg || results.ready;
    assign load           = em_ctl.valid && em_ready;
    assign out_valid_next = em_ready ? em_ctl.valid : out_valid_reg;

    // both factors are zero when no peak is carried
    assign prod     = PROD_W'(em_best) * PROD_W'(em_len);
    assign prod_ext = EXT_W'(prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_index_reg <= em_index;
            out_score_reg <= prod_ext[PRPS_SCORE_W-1:0];
            out_found_reg <= em_ctl.found;
            out_end_reg   <= em_ctl.line_end;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.peak_index = out_index_reg;
    assign results.peak_score = out_score_reg;
    assign results.peak_found = out_found_reg;
    assign results.line_end   = out_end_reg;

endmodule

// ----- design/prps_checker.sv -----
// ----------------------------------------------------------------------------
// prps_checker: port-level checks for the peak scorer
// result channel rules and result field consistency
// ----------------------------------------------------------------------------
module prps_checker
    import prps_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [PRPS_INDEX_W-1:0] peak_index,
    input logic [PRPS_SCORE_W-1:0] peak_score,
    input logic                    peak_found,
    input logic                    line_end
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(peak_index)
            && $stable(peak_score) && $stable(peak_found) && $stable(line_end))
        else $error("result changed while stalled");

    // a result without a peak carries zero fields
    a_no_peak_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !peak_found |-> peak_index == '0 && peak_score == '0)
        else $error("empty result carries nonzero fields");

    // a mid-line result only comes from a closed run
    a_mid_line_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_end |-> peak_found)
        else $error("mid-line result without a peak");

endmodule

bind positive_run_peak_scorer_unit prps_checker u_prps_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .peak_index (results.peak_index),
    .peak_score (results.peak_score),
    .peak_found (results.peak_found),
    .line_end   (results.line_end)
);
